/* sv/htfd_pkg.sv */
// ----------------------------------------------------------------------------
// htfd_pkg
// Types and constants for the humidity/temperature frame decoder: transfer
// payloads, the decoded frame record and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package htfd_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic [1:0]         frame_status;
	} out_item_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} frame_status_t;

	// Byte positions within a six-byte frame.
	typedef enum logic [2:0] {
		POS_TEMP_HI  = 3'd0,
		POS_TEMP_LO  = 3'd1,
		POS_TEMP_CRC = 3'd2,
		POS_HUM_HI   = 3'd3,
		POS_HUM_LO   = 3'd4,
		POS_HUM_CRC  = 3'd5
	} byte_pos_t;

	// Raw words and CRC verdict of one complete frame.
	typedef struct packed {
		logic [15:0]   temp_raw;
		logic [15:0]   hum_raw;
		frame_status_t status;
	} frame_t;

	localparam logic [7:0]  CRC_POLY        = 8'h31;
	localparam logic [7:0]  CRC_INIT        = 8'hFF;
	localparam logic [14:0] TEMP_SPAN_CENTI = 15'd17500;
	localparam logic [13:0] HUM_SPAN_CENTI  = 14'd10000;
	localparam logic signed [15:0] TEMP_OFFSET_CENTI = 16'sd4500;

	// One byte through the CRC-8 register, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* sv/htfd_rx.sv */
// ----------------------------------------------------------------------------
// htfd_rx
// Byte framing: tracks the position within the frame, runs the CRC over each
// word, collects the raw words and registers one frame record per frame.
// ----------------------------------------------------------------------------
module htfd_rx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              advance,
	input  htfd_pkg::in_item_t item,
	output logic              frame_valid_s1,
	output htfd_pkg::frame_t  frame_s1
);
	import htfd_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_raw_q;
	logic [15:0] hum_raw_q;
	logic        temp_bad_q;

	logic [2:0] pos_eff;
	logic [7:0] crc_eff;
	logic [7:0] crc_next;
	logic       crc_match;
	logic       last_byte;

	// A frame start, or a position that cannot occur, begins a fresh frame.
	always_comb begin
		if (item.frame_start || pos_q > POS_HUM_CRC) begin
			pos_eff = POS_TEMP_HI;
			crc_eff = CRC_INIT;
		end else begin
			pos_eff = pos_q;
			crc_eff = crc_q;
		end
		crc_next  = crc8_byte(crc_eff, item.rx_byte);
		crc_match = (item.rx_byte == crc_eff);
		last_byte = (pos_eff == POS_HUM_CRC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_TEMP_HI;
			crc_q      <= CRC_INIT;
			temp_raw_q <= '0;
			hum_raw_q  <= '0;
			temp_bad_q <= 1'b0;
		end else if (accept) begin
			pos_q <= last_byte ? POS_TEMP_HI : pos_eff + 3'd1;
			case (pos_eff)
				POS_TEMP_HI: begin
					temp_raw_q[15:8] <= item.rx_byte;
					crc_q            <= crc_next;
				end
				POS_TEMP_LO: begin
					temp_raw_q[7:0] <= item.rx_byte;
					crc_q           <= crc_next;
				end
				POS_TEMP_CRC: begin
					temp_bad_q <= !crc_match;
					crc_q      <= CRC_INIT;
				end
				POS_HUM_HI: begin
					hum_raw_q[15:8] <= item.rx_byte;
					crc_q           <= crc_next;
				end
				POS_HUM_LO: begin
					hum_raw_q[7:0] <= item.rx_byte;
					crc_q          <= crc_next;
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (advance) begin
			frame_valid_s1 <= accept && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			frame_s1.temp_raw <= temp_raw_q;
			frame_s1.hum_raw  <= hum_raw_q;
			if (temp_bad_q) begin
				frame_s1.status <= STATUS_TEMP_CRC;
			end else if (!crc_match) begin
				frame_s1.status <= STATUS_HUM_CRC;
			end else begin
				frame_s1.status <= STATUS_OK;
			end
		end
	end

endmodule

/* sv/htfd_scale.sv */
// ----------------------------------------------------------------------------
// htfd_scale
// Converts raw words to centi-units: a product stage, then division by 65535
// and the temperature offset into the output register.
// ----------------------------------------------------------------------------
module htfd_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid_s1,
	input  htfd_pkg::frame_t   frame_s1,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output htfd_pkg::out_item_t out_data
);
	import htfd_pkg::*;

	logic          valid_s2;
	logic [30:0]   temp_prod_s2;
	logic [29:0]   hum_prod_s2;
	frame_status_t status_s2;

	logic load_out;
	logic load_s2;

	logic [31:0] temp_sum;
	logic [31:0] hum_sum;
	logic [15:0] temp_quot;
	logic [15:0] hum_quot;
	logic signed [15:0] temp_centi;

	assign load_out = !out_valid || out_ready;
	assign load_s2  = !valid_s2 || load_out;
	assign take     = load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && frame_valid_s1) begin
			temp_prod_s2 <= 31'(frame_s1.temp_raw) * 31'(TEMP_SPAN_CENTI);
			hum_prod_s2  <= 30'(frame_s1.hum_raw) * 30'(HUM_SPAN_CENTI);
			status_s2    <= frame_s1.status;
		end
	end

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16, exact for x below 2^31.
	always_comb begin
		temp_sum   = 32'(temp_prod_s2) + 32'(temp_prod_s2 >> 16) + 32'd1;
		hum_sum    = 32'(hum_prod_s2) + 32'(hum_prod_s2 >> 16) + 32'd1;
		temp_quot  = temp_sum[31:16];
		hum_quot   = hum_sum[31:16];
		temp_centi = signed'({1'b0, temp_quot[14:0]}) - TEMP_OFFSET_CENTI;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && valid_s2) begin
			out_data.frame_status <= status_s2;
			if (status_s2 == STATUS_OK) begin
				out_data.temperature_centi <= temp_centi[14:0];
				out_data.humidity_centi    <= hum_quot[13:0];
			end else begin
				out_data.temperature_centi <= '0;
				out_data.humidity_centi    <= '0;
			end
		end
	end

endmodule

/* sv/humidity_temperature_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_core
// Decodes six-byte sensor frames (two CRC-8 checked words) into temperature
// and humidity in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one frame byte per
//   transfer, in bus order, with frame_start marking the first byte of a
//   frame. The output channel (out_valid, out_ready, out_data) carries one
//   result per complete frame; bytes that do not end a frame give no result.
//   Throughput is one byte per cycle while the output does not back up the
//   pipeline. The CRC is updated in the same cycle a byte is taken, so the
//   frame tracking never holds up the input. After the transfer of the sixth
//   byte a result passes the frame record register, the multiplier register
//   and the output register, in that order, before out_valid rises.
//   When the receiver stalls, the three registers fill and in_ready drops
//   only once all of them hold a result; a waiting result never blocks bytes
//   that complete no frame until the pipeline is full.
//   Reset clears the frame position, the CRC to 0xFF and all valid flags;
//   any partly received frame is lost.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  htfd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output htfd_pkg::out_item_t out_data
);
	import htfd_pkg::*;

	logic   frame_valid_s1;
	frame_t frame_s1;
	logic   take_s1;
	logic   advance_s1;
	logic   accept;

	assign advance_s1 = !frame_valid_s1 || take_s1;
	assign in_ready   = advance_s1;
	assign accept     = in_valid && in_ready;

	htfd_rx u_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.advance        (advance_s1),
		.item           (in_data),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	htfd_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.take           (take_s1),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

endmodule
